FILE: rtl/npsd_pkg.sv
// Shared types and constants for the node pair square distance inverse unit.
// No dependencies.
`timescale 1ns / 1ps
package npsd_pkg;
    localparam int CoordW = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int SqW    = 33;
    localparam int ProdW  = 2 * DiffW;
    localparam int InvW   = 48;
    localparam int QuoW   = InvW + 1;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegSquareRange = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMinSquare   = 2'd1;

    localparam logic [SqW-1:0] SquareRangeReset = {SqW{1'b1}};
    localparam logic [SqW-1:0] MinSquareReset   = '0;

    typedef struct packed {
        logic            valid;
        logic [SqW-1:0]  d;
        logic [SqW-1:0]  rem;
        logic [QuoW-1:0] q;
        logic            nb;
        logic            re;
        logic            win;
    } div_t;
endpackage

FILE: rtl/node_pair_square_distance_inverse_unit.sv
// Top level of the node pair square distance inverse unit.
// Depends on npsd_pkg, npsd_front and npsd_div_stage.
//
// Usage:
//   Raise start with a node pair on ref_x/ref_y/other_x/other_y, is_neighbour
//   and row_end_in; the pair transfers at each rising edge with start high.
//   busy is always low: a new pair may transfer in every cycle.
//   For each pair, done is high for one cycle with raw_square_dist,
//   masked_square_dist, inv_sq_distance and row_end_out. Results leave in
//   input order, one per pair, one per cycle at full rate.
//   The pipeline is four front stages (difference, square, sum, window test),
//   49 restoring division stages, one quotient bit each, and one output stage.
//   Registers are written through cfg_we/cfg_index/cfg_wdata, index 0
//   square_range, index 1 min_square; other indexes are dropped. The user
//   must write only while no pair is in flight; the block does not check.
//   Reset clears all valid bits and sets square_range to all ones and
//   min_square to zero. The receiver cannot stall: done is never held.
`timescale 1ns / 1ps
module node_pair_square_distance_inverse_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [npsd_pkg::CoordW-1:0]   ref_x,
    input  logic signed [npsd_pkg::CoordW-1:0]   ref_y,
    input  logic signed [npsd_pkg::CoordW-1:0]   other_x,
    input  logic signed [npsd_pkg::CoordW-1:0]   other_y,
    input  logic                                 is_neighbour,
    input  logic                                 row_end_in,
    input  logic                                 cfg_we,
    input  logic [npsd_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [npsd_pkg::SqW-1:0]             cfg_wdata,
    output logic                                 done,
    output logic [npsd_pkg::SqW-1:0]             raw_square_dist,
    output logic [npsd_pkg::SqW-1:0]             masked_square_dist,
    output logic [npsd_pkg::InvW-1:0]            inv_sq_distance,
    output logic                                 row_end_out
);
    import npsd_pkg::*;

    logic [SqW-1:0] square_range_reg, min_square_reg;
    div_t chain [QuoW+1];
    logic done_reg, re_reg;
    logic [SqW-1:0] raw_reg, masked_reg;
    logic [InvW-1:0] inv_reg;
    div_t last;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_range_reg <= SquareRangeReset;
            min_square_reg   <= MinSquareReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegSquareRange: square_range_reg <= cfg_wdata;
                RegMinSquare:   min_square_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    npsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .ref_x        (ref_x),
        .ref_y        (ref_y),
        .other_x      (other_x),
        .other_y      (other_y),
        .is_neighbour (is_neighbour),
        .row_end_in   (row_end_in),
        .square_range (square_range_reg),
        .min_square   (min_square_reg),
        .out          (chain[0])
    );

    for (genvar i = 0; i < QuoW; i++)
    begin : g_div
        npsd_div_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .num_bit ((i == 0) ? 1'b1 : 1'b0),
            .in      (chain[i]),
            .out     (chain[i+1])
        );
    end

    assign last = chain[QuoW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= last.d;
        masked_reg <= last.nb ? last.d : '0;
        re_reg     <= last.re;
        if (!last.win)
            inv_reg <= '0;
        else if (last.q[QuoW-1])
            inv_reg <= {InvW{1'b1}};
        else
            inv_reg <= last.q[InvW-1:0];
    end

    assign done               = done_reg;
    assign raw_square_dist    = raw_reg;
    assign masked_square_dist = masked_reg;
    assign inv_sq_distance    = inv_reg;
    assign row_end_out        = re_reg;

    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (done && masked_square_dist != '0) |-> masked_square_dist == raw_square_dist)
        else $error("masked distance differs from raw distance");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && inv_sq_distance != '0) |-> raw_square_dist != '0)
        else $error("inverse given for zero distance");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && raw_square_dist == SqW'(1) && inv_sq_distance != '0)
        |-> inv_sq_distance == {InvW{1'b1}})
        else $error("inverse of unit distance not saturated");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].valid |-> ##(QuoW + 1) done)
        else $error("front item lost in divider chain");
endmodule

FILE: rtl/npsd_front.sv
// Front pipeline: differences, squares, sum and window test (four stages).
// Depends on npsd_pkg.
`timescale 1ns / 1ps
module npsd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [npsd_pkg::CoordW-1:0] ref_x,
    input  logic signed [npsd_pkg::CoordW-1:0] ref_y,
    input  logic signed [npsd_pkg::CoordW-1:0] other_x,
    input  logic signed [npsd_pkg::CoordW-1:0] other_y,
    input  logic                            is_neighbour,
    input  logic                            row_end_in,
    input  logic [npsd_pkg::SqW-1:0]        square_range,
    input  logic [npsd_pkg::SqW-1:0]        min_square,
    output npsd_pkg::div_t                  out
);
    import npsd_pkg::*;

    logic [3:0] v_reg;
    logic signed [DiffW-1:0] dx_reg, dy_reg;
    logic [ProdW-1:0] sqx_reg, sqy_reg;
    logic [SqW-1:0] d3_reg, d4_reg;
    logic [2:0] nb_reg, re_reg;
    logic nb4_reg, re4_reg, win_reg;
    logic signed [ProdW-1:0] sqx_next, sqy_next;
    logic [ProdW:0] sum_next;

    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= DiffW'(ref_x) - DiffW'(other_x);
        dy_reg  <= DiffW'(ref_y) - DiffW'(other_y);
        sqx_reg <= ProdW'(unsigned'(sqx_next));
        sqy_reg <= ProdW'(unsigned'(sqy_next));
        d3_reg  <= sum_next[SqW-1:0];
        d4_reg  <= d3_reg;
        win_reg <= (d3_reg > min_square) && (d3_reg < square_range);
        nb_reg  <= {nb_reg[1:0], is_neighbour};
        re_reg  <= {re_reg[1:0], row_end_in};
        nb4_reg <= nb_reg[2];
        re4_reg <= re_reg[2];
    end

    always_comb
    begin
        out.valid = v_reg[3];
        out.d     = d4_reg;
        out.rem   = '0;
        out.q     = '0;
        out.nb    = nb4_reg;
        out.re    = re4_reg;
        out.win   = win_reg;
    end
endmodule

FILE: rtl/npsd_div_stage.sv
// One restoring division stage: one quotient bit of 2^48 / d per cycle.
// Depends on npsd_pkg.
`timescale 1ns / 1ps
module npsd_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           num_bit,
    input  npsd_pkg::div_t in,
    output npsd_pkg::div_t out
);
    import npsd_pkg::*;

    div_t st_reg;
    div_t st_next;
    logic [SqW:0] sh;
    logic [SqW:0] diff;
    logic ge;

    always_comb
    begin
        sh   = {in.rem, num_bit};
        ge   = sh >= {1'b0, in.d};
        diff = sh - {1'b0, in.d};
        st_next     = in;
        st_next.rem = ge ? diff[SqW-1:0] : sh[SqW-1:0];
        st_next.q   = {in.q[QuoW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign out = st_reg;
endmodule
